// File: rtl/spf_pkg.sv
// ----------------------------------------------------------------------------
// spf_pkg: shared types and constants of the packet framer
// Item and result structs, the queued command format and sequencer step codes.
// ----------------------------------------------------------------------------
package spf_pkg;

    localparam int unsigned MAX_PAYLOAD_DEF = 64;
    localparam int unsigned QUEUE_DEPTH_DEF = 4;
    localparam int unsigned LEN_W           = 7;
    localparam logic [15:0] FRAME_OVERHEAD  = 16'd16;

    typedef struct packed {
        logic             frame_start;
        logic [31:0]      message_id;
        logic [LEN_W-1:0] payload_length;
        logic             has_byte;
        logic [7:0]       data_byte;
    } item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       end_of_frame;
    } frame_byte_t;

    // One classified item, as handed from the front end to the sequencer.
    typedef struct packed {
        logic             start;
        logic [31:0]      id;
        logic [LEN_W-1:0] len;
        logic             pay;
        logic [7:0]       data;
        logic             close;
    } cmd_t;

    typedef logic [4:0] step_t;

    localparam step_t STEP_HDR_FIRST = 5'd0;
    localparam step_t STEP_HDR_WORD  = 5'd3;
    localparam step_t STEP_FLEN_LO   = 5'd4;
    localparam step_t STEP_FLEN_HI   = 5'd5;
    localparam step_t STEP_ID_FIRST  = 5'd6;
    localparam step_t STEP_ID_LAST   = 5'd9;
    localparam step_t STEP_PLEN_LO   = 5'd10;
    localparam step_t STEP_PLEN_PAD  = 5'd11;
    localparam step_t STEP_HDR_LAST  = 5'd13;
    localparam step_t STEP_PAYLOAD   = 5'd16;
    localparam step_t STEP_SUM_LO    = 5'd17;
    localparam step_t STEP_SUM_HI    = 5'd18;

    // The four-character frame marker, sent first.
    function automatic logic [7:0] header_byte(input logic [1:0] idx);
        logic [7:0] b;
        case (idx)
            2'd0:    b = 8'h48;
            2'd1:    b = 8'h43;
            2'd2:    b = 8'h5A;
            default: b = 8'h4E;
        endcase
        return b;
    endfunction

endpackage

// File: rtl/serial_packet_framer_sum16.sv
// ----------------------------------------------------------------------------
// serial_packet_framer_sum16: byte-serial packet framer with 16-bit byte sum
// Classifies items, queues them, streams framed bytes one per cycle when unstalled.
// ----------------------------------------------------------------------------
// The first byte caused by an item passes through the command queue and then the
// output register. A start causes the fourteen header bytes, and closing the frame
// adds the two checksum bytes; the byte sequencer sends one byte per cycle while the
// output is not stalled, and the queue absorbs bursts meanwhile.
// Reset is asynchronous and active low: no frame open, queue empty, output idle.
// ----------------------------------------------------------------------------
module serial_packet_framer_sum16
    import spf_pkg::*;
#(
    parameter int unsigned MAX_PAYLOAD = MAX_PAYLOAD_DEF,
    parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_stall,
    input  item_t       item_data,
    output logic        frame_valid,
    input  logic        frame_stall,
    output frame_byte_t frame_data
);

    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH+1);

    // The front end decides, for every transfer, which bytes it will cause: the
    // fourteen header bytes on a start, a payload byte while the frame still
    // expects one, and the two checksum bytes once the last counted byte is in.
    // It keeps only the count of payload bytes still expected.
    cmd_t             push_cmd;
    cmd_t             head_cmd;
    logic             push;
    logic             pop;
    logic             q_full;
    logic             q_empty;
    logic [CNT_W-1:0] q_count;
    logic [LEN_W-1:0] remaining;

    spf_front #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item_data  (item_data),
        .q_full     (q_full),
        .push       (push),
        .cmd        (push_cmd),
        .remaining  (remaining)
    );

    // The queue lets the front end keep taking payload bytes while the
    // sequencer is still busy sending a header.
    spf_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .wr_cmd (push_cmd),
        .pop    (pop),
        .head   (head_cmd),
        .full   (q_full),
        .empty  (q_empty),
        .count  (q_count)
    );

    // The sequencer owns the running sum, which a start resets, so a frame that
    // is abandoned by a new start simply never gets its checksum.
    spf_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head_cmd),
        .q_empty     (q_empty),
        .pop         (pop),
        .frame_valid (frame_valid),
        .frame_stall (frame_stall),
        .frame_data  (frame_data)
    );

    // The queue never holds more commands than it has entries.
    assert property (@(posedge clk) disable iff (!rst_n)
        q_count <= CNT_W'(QUEUE_DEPTH))
        else $error("command queue over-filled");

    // Every start transfer leaves at least one command queued for the sequencer.
    assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && !item_stall && item_data.frame_start) |=> !q_empty)
        else $error("start transfer produced no queued command");

    // The expected payload count stays within the clamped maximum.
    assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, remaining} <= 8'(MAX_PAYLOAD))
        else $error("payload count above maximum");

endmodule

// File: rtl/spf_front.sv
// ----------------------------------------------------------------------------
// spf_front: item classifier
// Tracks the open frame and turns each accepted item into a queued command.
// ----------------------------------------------------------------------------
module spf_front
    import spf_pkg::*;
#(
    parameter int unsigned MAX_PAYLOAD = MAX_PAYLOAD_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_stall,
    input  item_t            item_data,
    input  logic             q_full,
    output logic             push,
    output cmd_t             cmd,
    output logic [LEN_W-1:0] remaining
);

    logic [LEN_W-1:0] rem_reg;
    logic [LEN_W-1:0] rem_next;
    logic [LEN_W-1:0] len_sat;
    logic             accept;
    logic             emit;

    assign item_stall = q_full;
    assign accept     = item_valid && !q_full;
    assign push       = accept && emit;
    assign remaining  = rem_reg;

    // Lengths beyond the maximum are clamped, both in the header and the count.
    assign len_sat = ({1'b0, item_data.payload_length} > 8'(MAX_PAYLOAD))
                     ? LEN_W'(MAX_PAYLOAD) : item_data.payload_length;

    always_comb
    begin
        cmd      = '0;
        emit     = 1'b0;
        rem_next = rem_reg;
        cmd.id   = item_data.message_id;
        cmd.len  = len_sat;
        cmd.data = item_data.data_byte;
        if (item_data.frame_start)
        begin
            cmd.start = 1'b1;
            emit      = 1'b1;
            if (len_sat == '0)
            begin
                cmd.close = 1'b1;
                rem_next  = '0;
            end
            else if (item_data.has_byte)
            begin
                cmd.pay   = 1'b1;
                cmd.close = (len_sat == LEN_W'(1));
                rem_next  = len_sat - LEN_W'(1);
            end
            else
            begin
                rem_next = len_sat;
            end
        end
        else if (item_data.has_byte && (rem_reg != '0))
        begin
            cmd.pay   = 1'b1;
            emit      = 1'b1;
            cmd.close = (rem_reg == LEN_W'(1));
            rem_next  = rem_reg - LEN_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg <= '0;
        end
        else if (accept)
        begin
            rem_reg <= rem_next;
        end
    end

endmodule

// File: rtl/spf_fifo.sv
// ----------------------------------------------------------------------------
// spf_fifo: command queue
// Small register queue between the classifier and the byte sequencer.
// ----------------------------------------------------------------------------
module spf_fifo
    import spf_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push,
    input  cmd_t                     wr_cmd,
    input  logic                     pop,
    output cmd_t                     head,
    output logic                     full,
    output logic                     empty,
    output logic [$clog2(DEPTH+1)-1:0] count
);

    // DEPTH must be a power of two of at least two, so the pointers wrap.
    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH+1);

    cmd_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign head  = mem_reg[rd_ptr_reg];
    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);
    assign count = count_reg;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

endmodule

// File: rtl/spf_back.sv
// ----------------------------------------------------------------------------
// spf_back: byte sequencer
// Walks each queued command through its wire bytes, keeps the running sum and
// drives the output register.
// ----------------------------------------------------------------------------
module spf_back
    import spf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cmd_t        head,
    input  logic        q_empty,
    output logic        pop,
    output logic        frame_valid,
    input  logic        frame_stall,
    output frame_byte_t frame_data
);

    logic        started_reg;
    logic        started_next;
    step_t       step_reg;
    step_t       step_next;
    step_t       cur_step;
    logic [15:0] sum_reg;
    logic [15:0] sum_next;
    logic [15:0] sum_base;
    logic [15:0] flen;
    logic [1:0]  id_idx;
    logic [7:0]  cur_byte;
    logic        is_last;
    logic        fire;
    logic        out_valid_reg;
    frame_byte_t out_data_reg;

    assign frame_valid = out_valid_reg;
    assign frame_data  = out_data_reg;

    assign fire = !q_empty && (!out_valid_reg || !frame_stall);
    assign pop  = fire && is_last;

    // A fresh command starts at its first byte; later bytes follow the stored step.
    always_comb
    begin
        if (started_reg)
        begin
            cur_step = step_reg;
        end
        else if (head.start)
        begin
            cur_step = STEP_HDR_FIRST;
        end
        else if (head.pay)
        begin
            cur_step = STEP_PAYLOAD;
        end
        else
        begin
            cur_step = STEP_SUM_LO;
        end
    end

    always_comb
    begin
        is_last = (cur_step == STEP_SUM_HI)
               || ((cur_step == STEP_PAYLOAD) && !head.close)
               || ((cur_step == STEP_HDR_LAST) && !head.pay && !head.close);
        if (cur_step == STEP_HDR_LAST)
        begin
            step_next = head.pay ? STEP_PAYLOAD : STEP_SUM_LO;
        end
        else if (cur_step == STEP_PAYLOAD)
        begin
            step_next = STEP_SUM_LO;
        end
        else
        begin
            step_next = cur_step + step_t'(1);
        end
        started_next = !is_last;
    end

    assign flen   = FRAME_OVERHEAD + 16'(head.len);
    assign id_idx = 2'(cur_step - STEP_ID_FIRST);

    always_comb
    begin
        unique case (cur_step) inside
            [STEP_HDR_FIRST:STEP_HDR_WORD]: cur_byte = header_byte(cur_step[1:0]);
            STEP_FLEN_LO:                   cur_byte = flen[7:0];
            STEP_FLEN_HI:                   cur_byte = flen[15:8];
            [STEP_ID_FIRST:STEP_ID_LAST]:   cur_byte = head.id[8*id_idx +: 8];
            STEP_PLEN_LO:                   cur_byte = 8'(head.len);
            [STEP_PLEN_PAD:STEP_HDR_LAST]:  cur_byte = 8'h00;
            STEP_PAYLOAD:                   cur_byte = head.data;
            STEP_SUM_LO:                    cur_byte = sum_reg[7:0];
            STEP_SUM_HI:                    cur_byte = sum_reg[15:8];
            default:                        cur_byte = 8'h00;
        endcase
    end

    // Every byte up to and including the payload counts; the checksum does not.
    assign sum_base = (cur_step == STEP_HDR_FIRST) ? 16'd0 : sum_reg;
    assign sum_next = (cur_step <= STEP_PAYLOAD) ? (sum_base + 16'(cur_byte)) : sum_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            started_reg   <= 1'b0;
            step_reg      <= STEP_HDR_FIRST;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                started_reg   <= started_next;
                step_reg      <= step_next;
                sum_reg       <= sum_next;
                out_valid_reg <= 1'b1;
            end
            else if (!frame_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_data_reg.out_byte     <= cur_byte;
            out_data_reg.end_of_frame <= (cur_step == STEP_SUM_HI);
        end
    end

endmodule
